### rtl/mahs_pkg.sv
// shared types and constants for the multi-axis homing sequencer
// no dependencies; imported by the interfaces and every module

package mahs_pkg;

    localparam int AXIS_COUNT_DEF = 4;
    localparam int FIELD_LANES    = 4;

    localparam int AXES_W  = 4;
    localparam int DIR_W   = 2;
    localparam int COUNT_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [DIR_W-1:0] DIR_APPROACH = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BACKOFF  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_NONE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_HOME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_HOME = 2'd1;

    typedef enum logic [2:0] {
        PH_DONE     = 3'b001,
        PH_APPROACH = 3'b010,
        PH_BACKOFF  = 3'b100
    } t_phase;

    // broadcast to every lane
    typedef struct packed {
        logic             accept;
        logic             opcode;
        logic [DIR_W-1:0] start_direction;
    } t_lane_ctl;

    // what one lane found for the current request
    typedef struct packed {
        logic active_next;
        logic step;
        logic dir_bit;
    } t_lane_res;

    typedef struct packed {
        logic [AXES_W-1:0]  step_bits;
        logic [AXES_W-1:0]  dir_out;
        logic [COUNT_W-1:0] unhomed_count;
        logic               all_homed;
    } t_res;

endpackage

### rtl/mahs_ifs.sv
// request, result and configuration channel interfaces
// depends on mahs_pkg for field widths

interface mahs_req_if;
    import mahs_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [AXES_W-1:0] axes_mask;
    logic [DIR_W-1:0]  start_direction;
    logic [AXES_W-1:0] limit_bits;

    modport source(output valid, opcode, axes_mask, start_direction, limit_bits, input ready);
    modport sink(input valid, opcode, axes_mask, start_direction, limit_bits, output ready);
endinterface

interface mahs_res_if;
    import mahs_pkg::*;
    logic               valid;
    logic               ready;
    logic [AXES_W-1:0]  step_bits;
    logic [AXES_W-1:0]  dir_out;
    logic [COUNT_W-1:0] unhomed_count;
    logic               all_homed;

    modport source(output valid, step_bits, dir_out, unhomed_count, all_homed, input ready);
    modport sink(input valid, step_bits, dir_out, unhomed_count, all_homed, output ready);
endinterface

interface mahs_cfg_if;
    import mahs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, idx, data, input ready);
    modport sink(input valid, idx, data, output ready);
endinterface

### rtl/mahs_lane.sv
// one axis of the homing sequencer: phase register and limit switch logic
// depends on mahs_pkg

module mahs_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mahs_pkg::t_lane_ctl   i_ctl,
    input  logic                  i_sel,
    input  logic                  i_limit,
    input  logic                  i_invert,
    input  logic                  i_reverse,
    output mahs_pkg::t_lane_res   o_res
);
    import mahs_pkg::*;

    t_phase r_phase;
    t_phase n_phase;
    logic   w_active;
    logic   w_switch;

    assign w_active = (r_phase != PH_DONE);
    assign w_switch = i_limit ^ i_invert ^ (r_phase == PH_BACKOFF);

    always_comb begin
        n_phase = r_phase;
        case (i_ctl.opcode)
            OP_START: begin
                n_phase = PH_DONE;
                if (i_sel) begin
                    if (i_ctl.start_direction == DIR_APPROACH) begin
                        n_phase = PH_APPROACH;
                    end else if (i_ctl.start_direction == DIR_BACKOFF) begin
                        n_phase = PH_BACKOFF;
                    end
                end
            end
            OP_TICK: begin
                if (w_active && w_switch) begin
                    n_phase = PH_DONE;
                end
            end
            default: n_phase = r_phase;
        endcase
    end

    assign o_res.active_next = (n_phase != PH_DONE);
    assign o_res.step        = (i_ctl.opcode == OP_TICK) && w_active && !w_switch;
    assign o_res.dir_bit     = (n_phase == PH_BACKOFF) ^ i_reverse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
        end else if (i_ctl.accept) begin
            r_phase <= n_phase;
        end
    end

endmodule

### rtl/mahs_merge.sv
// merging stage: combines lane results, holds the direction latch and
// a two-entry result buffer; depends on mahs_pkg and mahs_ifs

module mahs_merge #(
    parameter int AXIS_COUNT = mahs_pkg::AXIS_COUNT_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  mahs_pkg::t_lane_ctl                           i_ctl,
    input  mahs_pkg::t_lane_res [mahs_pkg::FIELD_LANES-1:0] i_lanes,
    output logic                                          o_in_ready,
    mahs_res_if.source                                    o_res
);
    import mahs_pkg::*;

    localparam int LANES = (AXIS_COUNT < FIELD_LANES) ? AXIS_COUNT : FIELD_LANES;

    logic [COUNT_W-1:0] w_count;
    logic [AXES_W-1:0]  w_steps;
    logic [AXES_W-1:0]  w_dirs;
    logic [AXES_W-1:0]  r_dir;
    logic [AXES_W-1:0]  n_dir;
    t_res               w_new;
    t_res               r_head;
    t_res               n_head;
    t_res               r_skid;
    t_res               n_skid;
    logic               r_head_v;
    logic               n_head_v;
    logic               r_skid_v;
    logic               n_skid_v;
    logic               w_pop;

    always_comb begin
        w_count = '0;
        for (int i = 0; i < FIELD_LANES; i++) begin
            w_count = w_count + COUNT_W'(i_lanes[i].active_next);
            w_steps[i] = i_lanes[i].step;
            w_dirs[i]  = i_lanes[i].dir_bit;
        end
    end

    always_comb begin
        n_dir = r_dir;
        if (i_ctl.accept && (i_ctl.opcode == OP_START) && (w_count != '0)) begin
            n_dir = w_dirs;
        end
    end

    assign w_new.step_bits     = w_steps;
    assign w_new.dir_out       = n_dir;
    assign w_new.unhomed_count = w_count;
    assign w_new.all_homed     = (w_count == '0);

    assign w_pop = r_head_v && o_res.ready;

    always_comb begin
        n_head   = r_head;
        n_head_v = r_head_v;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (w_pop) begin
            if (r_skid_v) begin
                n_head   = r_skid;
                n_skid   = w_new;
                n_skid_v = i_ctl.accept;
            end else begin
                n_head   = w_new;
                n_head_v = i_ctl.accept;
            end
        end else if (i_ctl.accept) begin
            if (!r_head_v) begin
                n_head   = w_new;
                n_head_v = 1'b1;
            end else begin
                n_skid   = w_new;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
            r_dir    <= '0;
        end else begin
            r_head_v <= n_head_v;
            r_skid_v <= n_skid_v;
            r_dir    <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_in_ready          = !r_skid_v;
    assign o_res.valid         = r_head_v;
    assign o_res.step_bits     = r_head.step_bits;
    assign o_res.dir_out       = r_head.dir_out;
    assign o_res.unhomed_count = r_head.unhomed_count;
    assign o_res.all_homed     = r_head.all_homed;

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_head_v)
        else $error("skid entry held without a head entry");

    a_homed_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_v |-> (r_head.all_homed == (r_head.unhomed_count == '0)))
        else $error("all_homed disagrees with unhomed_count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_v |-> (r_head.unhomed_count <= COUNT_W'(LANES)))
        else $error("unhomed_count exceeds the number of lanes");

    a_start_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && (i_ctl.opcode == OP_START)) |-> (w_steps == '0))
        else $error("step requested on a start request");

endmodule

### rtl/multi_axis_homing_sequencer.sv
// top level of the multi-axis homing sequencer: configuration registers,
// one lane per axis and the merging stage; depends on mahs_pkg and mahs_ifs

// Takes one request per clock while the buffer has room and gives exactly one
// result per request; the result is offered in the cycle after the request is
// taken, or later when older results still wait on the result channel. Every
// axis lane updates its phase in that same cycle, so requests may follow each
// other with no gap; a two-entry result buffer lets one request in while a
// result still waits, and the request channel only stalls when both entries
// are full. The configuration channel is always ready and a write lands at
// its handshake edge; writes to an index beyond the two registers are dropped.

module multi_axis_homing_sequencer #(
    parameter int AXIS_COUNT = mahs_pkg::AXIS_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mahs_req_if.sink    i_req,
    mahs_cfg_if.sink    i_cfg,
    mahs_res_if.source  o_res
);
    import mahs_pkg::*;

    localparam int LANES = (AXIS_COUNT < FIELD_LANES) ? AXIS_COUNT : FIELD_LANES;

    logic [AXES_W-1:0]            r_invert;
    logic [AXES_W-1:0]            r_reverse;
    logic                         w_in_ready;
    t_lane_ctl                    w_ctl;
    t_lane_res [FIELD_LANES-1:0]  w_lanes;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert  <= '0;
            r_reverse <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                CFG_INVERT_HOME:  r_invert  <= i_cfg.data[AXES_W-1:0];
                CFG_REVERSE_HOME: r_reverse <= i_cfg.data[AXES_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_req.ready           = w_in_ready;
    assign w_ctl.accept          = i_req.valid && w_in_ready;
    assign w_ctl.opcode          = i_req.opcode;
    assign w_ctl.start_direction = i_req.start_direction;

    for (genvar g = 0; g < FIELD_LANES; g++) begin : g_lane
        if (g < LANES) begin : g_used
            mahs_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_sel     (i_req.axes_mask[g]),
                .i_limit   (i_req.limit_bits[g]),
                .i_invert  (r_invert[g]),
                .i_reverse (r_reverse[g]),
                .o_res     (w_lanes[g])
            );
        end else begin : g_unused
            assign w_lanes[g] = '0;
        end
    end

    mahs_merge #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_lanes    (w_lanes),
        .o_in_ready (w_in_ready),
        .o_res      (o_res)
    );

endmodule
